// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of the fade timer.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- rtl/core/rcft_pkg.sv -----
// Shared constants, codes and structs of the RGBA fade timer.
// Depends on nothing; imported by every other file of the block but assert_macros.svh.
package rcft_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int COLOR_W    = CH_W * NUM_CH;
    localparam int LEN_W      = 16;
    localparam int ELAPSED_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = CH_W + FRAC_BITS + 2;
    localparam int CNT_W      = $clog2(FRAC_BITS);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_COLOR = 2'd0,
        REG_END_COLOR   = 2'd1,
        REG_FADE_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             launch;
        logic             finished;
        logic [LEN_W-1:0] elapsed;
    } rcft_cmd_t;

    typedef struct packed {
        logic               busy;
        logic               valid;
        logic               finished;
        logic [COLOR_W-1:0] color;
    } rcft_res_t;

endpackage

// ----- rtl/core/rcft_if.sv -----
// Input and output channel interfaces of the RGBA fade timer.
// Depends on rcft_pkg for field widths.
interface rcft_in_if import rcft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [LEN_W-1:0] tick_amount;

    modport source (output valid, output opcode, output tick_amount, input ready);
    modport sink (input valid, input opcode, input tick_amount, output ready);
endinterface

interface rcft_out_if import rcft_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            finished;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output finished, input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  input finished, output ready);
endinterface

// ----- rtl/core/rgba_color_fade_timer.sv -----
// RGBA fade timer: a start transaction arms the fade and clears the elapsed time; each
// tick transaction while armed adds its time units (saturating at 17 bits) and returns
// one colour, start_color blended toward end_color by min(elapsed, fade_length) /
// fade_length in Q0.16, with finished set and the fade disarmed once elapsed reaches
// fade_length. Start transactions and ticks while idle return nothing. A tick that
// completes the fade enters the interpolator's result state on acceptance; any other
// armed tick first runs the bit-serial divider, which forms one fraction bit per cycle
// and feeds the four channel shift-add accumulators. The result is then moved to the
// output register once that register is empty or being read. Input is refused while a
// tick is in the interpolator, so the next transaction is accepted at the earliest in
// the cycle the result reaches the output register; a result held in the output
// register blocks only the interpolator's next result, not the next transaction.
// Depends on rcft_pkg, rcft_if and rcft_interp.
module rgba_color_fade_timer
    import rcft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rcft_in_if.sink               in_chan,
    rcft_out_if.source            out_chan
);

    logic [COLOR_W-1:0]   start_color_reg;
    logic [COLOR_W-1:0]   end_color_reg;
    logic [LEN_W-1:0]     fade_length_reg;
    logic                 running_reg, running_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   color_reg;
    logic                 fin_reg;

    logic                 accept;
    logic                 is_start;
    logic [ELAPSED_W:0]   e_sum;
    logic [ELAPSED_W-1:0] e_new;
    logic                 done;
    logic                 take;
    rcft_cmd_t            cmd;
    rcft_res_t            res;

    assign in_chan.ready = !res.busy;
    assign accept        = in_chan.valid && in_chan.ready;
    assign is_start      = (in_chan.opcode == OP_START);

    assign e_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(in_chan.tick_amount);
    assign e_new = e_sum[ELAPSED_W] ? '1 : e_sum[ELAPSED_W-1:0];
    assign done  = (e_new >= ELAPSED_W'(fade_length_reg));

    assign cmd.launch   = accept && !is_start && running_reg;
    assign cmd.finished = done;
    assign cmd.elapsed  = e_new[LEN_W-1:0];

    always_comb
    begin
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        if (accept && is_start)
        begin
            running_next = 1'b1;
            elapsed_next = '0;
        end
        else if (cmd.launch)
        begin
            elapsed_next = e_new;
            if (done)
            begin
                running_next = 1'b0;
            end
        end
    end

    assign take           = res.valid && (!out_valid_reg || out_chan.ready);
    assign out_valid_next = take || (out_valid_reg && !out_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg <= '0;
            end_color_reg   <= '0;
            fade_length_reg <= LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_COLOR: start_color_reg <= cfg_data[COLOR_W-1:0];
                REG_END_COLOR:   end_color_reg   <= cfg_data[COLOR_W-1:0];
                REG_FADE_LENGTH: fade_length_reg <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            color_reg <= res.color;
            fin_reg   <= res.finished;
        end
    end

    rcft_interp u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_color (start_color_reg),
        .end_color   (end_color_reg),
        .fade_length (fade_length_reg),
        .take        (take),
        .res         (res)
    );

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.red      = color_reg[0*CH_W +: CH_W];
    assign out_chan.green    = color_reg[1*CH_W +: CH_W];
    assign out_chan.blue     = color_reg[2*CH_W +: CH_W];
    assign out_chan.alpha    = color_reg[3*CH_W +: CH_W];
    assign out_chan.finished = fin_reg;

endmodule

// ----- rtl/core/rcft_interp.sv -----
// Bit-serial fraction divider fused with a per-channel shift-add interpolator.
// Depends on rcft_pkg; instantiated by rgba_color_fade_timer.
module rcft_interp
    import rcft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rcft_cmd_t          cmd,
    input  logic [COLOR_W-1:0] start_color,
    input  logic [COLOR_W-1:0] end_color,
    input  logic [LEN_W-1:0]   fade_length,
    input  logic               take,
    output rcft_res_t          res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic                    fin_reg, fin_next;
    logic signed [ACC_W-1:0] acc_reg [NUM_CH];
    logic signed [ACC_W-1:0] acc_next [NUM_CH];

    logic [LEN_W:0]          rem2;
    logic [LEN_W:0]          rem_sub;
    logic                    qbit;
    logic signed [ACC_W-1:0] diff_ext [NUM_CH];
    logic signed [ACC_W-1:0] sum [NUM_CH];
    logic [COLOR_W-1:0]      color;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            diff_ext[ch] = $signed({{(ACC_W-CH_W){1'b0}}, end_color[ch*CH_W +: CH_W]})
                         - $signed({{(ACC_W-CH_W){1'b0}}, start_color[ch*CH_W +: CH_W]});
            sum[ch] = $signed({{(ACC_W-CH_W-FRAC_BITS){1'b0}}, start_color[ch*CH_W +: CH_W],
                               {FRAC_BITS{1'b0}}}) + acc_reg[ch];
            color[ch*CH_W +: CH_W] = sum[ch][FRAC_BITS +: CH_W];
        end
    end

    assign rem2    = {rem_reg, 1'b0};
    assign rem_sub = rem2 - {1'b0, fade_length};
    assign qbit    = (rem2 >= {1'b0, fade_length});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        fin_next   = fin_reg;
        acc_next   = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.launch)
                begin
                    fin_next = cmd.finished;
                    rem_next = cmd.elapsed;
                    cnt_next = CNT_W'(FRAC_BITS - 1);
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        acc_next[ch] = cmd.finished ? (diff_ext[ch] <<< FRAC_BITS) : '0;
                    end
                    state_next = cmd.finished ? S_DONE : S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? rem_sub[LEN_W-1:0] : rem2[LEN_W-1:0];
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    acc_next[ch] = (acc_reg[ch] <<< 1) + (qbit ? diff_ext[ch] : '0);
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            fin_reg   <= 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                acc_reg[ch] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            fin_reg   <= fin_next;
            acc_reg   <= acc_next;
        end
    end

    assign res.busy     = (state_reg != S_IDLE);
    assign res.valid    = (state_reg == S_DONE);
    assign res.finished = fin_reg;
    assign res.color    = color;

endmodule

// ----- rtl/core/rcft_checker.sv -----
// Port-level checks of the RGBA fade timer, bound to the top level.
// Depends on rcft_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcft_checker
    import rcft_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] red,
    input logic [CH_W-1:0] green,
    input logic [CH_W-1:0] blue,
    input logic [CH_W-1:0] alpha,
    input logic            finished
);

    logic [NUM_CH*CH_W:0] out_bits;

    assign out_bits = {red, green, blue, alpha, finished};

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits))
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    `ASSERT_SAME(a_result_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind rgba_color_fade_timer rcft_checker u_rcft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .red       (out_chan.red),
    .green     (out_chan.green),
    .blue      (out_chan.blue),
    .alpha     (out_chan.alpha),
    .finished  (out_chan.finished)
);
